// ===== src/triangle_map_distortion_assert.svh =====
// assertion macros for the triangle map distortion block
`ifndef TRIANGLE_MAP_DISTORTION_ASSERT_SVH
`define TRIANGLE_MAP_DISTORTION_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TMD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tmd assertion failed");
// next-cycle implication
`define TMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tmd assertion failed");
`else
`define TMD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define TMD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/tmd_pkg.sv =====
package tmd_pkg;

   // fixed point and datapath sizes
   localparam int FRAC_BITS  = 16;
   localparam int WIDE_BITS  = 344 + FRAC_BITS;
   localparam int CNT_BITS   = $clog2(WIDE_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WIDE_BITS - 1);
   localparam int COORD_BITS = 32;
   localparam int VEC_BITS   = 3 * COORD_BITS;
   localparam int SLOTS      = 8;
   localparam int ROW_BITS   = $clog2(SLOTS);
   localparam int DIST_BITS  = 48;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
   localparam int RF_DEPTH   = 32;
   localparam int RF_BITS    = $clog2(RF_DEPTH);

   // microcode layout
   localparam int PC_BITS    = 7;
   localparam int FRAME_LEN  = 42;
   localparam int FINAL_LEN  = 21;
   localparam int UOP_COUNT  = 2 * FRAME_LEN + FINAL_LEN;
   localparam logic [PC_BITS-1:0] UOP_LAST = PC_BITS'(UOP_COUNT - 1);

   typedef logic [WIDE_BITS-1:0] wide_type;

   typedef enum logic [2:0] {
      OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_ABS, OP_DIV
   } alu_op_type;

   typedef enum logic [1:0] {
      COMP_X, COMP_Y, COMP_Z
   } comp_type;

   typedef enum logic [RF_BITS-1:0] {
      RF_V0X, RF_V0Y, RF_V0Z, RF_E1X, RF_E1Y, RF_E1Z, RF_E2X, RF_E2Y, RF_E2Z,
      RF_N0, RF_N1, RF_N2, RF_T, RF_U, RF_L, RF_B, RF_C, RF_M, RF_Q, RF_R,
      RF_LM, RF_C2, RF_R2, RF_NUM, RF_DEN
   } rf_addr_type;

   typedef struct packed {
      alu_op_type  op;
      rf_addr_type dst;
      rf_addr_type a;
      rf_addr_type b;
      logic [ROW_BITS-1:0] slot;
      comp_type    comp;
      logic        zchk;
   } uop_type;

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_READ, SEQ_EXEC, SEQ_WAIT, SEQ_HOLD
   } seq_state_type;

   typedef enum logic [2:0] {
      ALU_IDLE, ALU_MUL, ALU_SIGN, ALU_DPREP, ALU_DIV, ALU_DONE
   } alu_state_type;

   typedef struct packed {
      logic done;
      logic sat;
   } alu_status_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distortion;
      logic                 degenerate;
      logic                 saturated;
   } result_type;

   // micro-op builders
   function automatic uop_type mk(alu_op_type op, rf_addr_type dst, rf_addr_type a,
                                  rf_addr_type b, logic [ROW_BITS-1:0] slot,
                                  comp_type comp, logic zchk);
      uop_type u;
      u.op   = op;
      u.dst  = dst;
      u.a    = a;
      u.b    = b;
      u.slot = slot;
      u.comp = comp;
      u.zchk = zchk;
      return u;
   endfunction

   function automatic uop_type ld(rf_addr_type dst, logic [ROW_BITS-1:0] slot,
                                  comp_type comp);
      return mk(OP_LD, dst, RF_T, RF_T, slot, comp, 1'b0);
   endfunction

   function automatic uop_type alu(alu_op_type op, rf_addr_type dst, rf_addr_type a,
                                   rf_addr_type b, logic zchk);
      return mk(op, dst, a, b, '0, COMP_X, zchk);
   endfunction

   // frame of one triangle: edge length squared, e1.e2 and n.(e1 x e2)
   function automatic uop_type frame_uop(logic [5:0] idx, logic [ROW_BITS-1:0] base,
                                         rf_addr_type fl, rf_addr_type fb,
                                         rf_addr_type fc);
      logic [ROW_BITS-1:0] s1;
      logic [ROW_BITS-1:0] s2;
      logic [ROW_BITS-1:0] s3;
      uop_type u;
      s1 = base + ROW_BITS'(1);
      s2 = base + ROW_BITS'(2);
      s3 = base + ROW_BITS'(3);
      case (idx)
         6'd0:  u = ld(RF_V0X, base, COMP_X);
         6'd1:  u = ld(RF_V0Y, base, COMP_Y);
         6'd2:  u = ld(RF_V0Z, base, COMP_Z);
         6'd3:  u = ld(RF_T, s1, COMP_X);
         6'd4:  u = alu(OP_SUB, RF_E1X, RF_T, RF_V0X, 1'b0);
         6'd5:  u = ld(RF_T, s1, COMP_Y);
         6'd6:  u = alu(OP_SUB, RF_E1Y, RF_T, RF_V0Y, 1'b0);
         6'd7:  u = ld(RF_T, s1, COMP_Z);
         6'd8:  u = alu(OP_SUB, RF_E1Z, RF_T, RF_V0Z, 1'b0);
         6'd9:  u = ld(RF_T, s2, COMP_X);
         6'd10: u = alu(OP_SUB, RF_E2X, RF_T, RF_V0X, 1'b0);
         6'd11: u = ld(RF_T, s2, COMP_Y);
         6'd12: u = alu(OP_SUB, RF_E2Y, RF_T, RF_V0Y, 1'b0);
         6'd13: u = ld(RF_T, s2, COMP_Z);
         6'd14: u = alu(OP_SUB, RF_E2Z, RF_T, RF_V0Z, 1'b0);
         6'd15: u = ld(RF_N0, s3, COMP_X);
         6'd16: u = ld(RF_N1, s3, COMP_Y);
         6'd17: u = ld(RF_N2, s3, COMP_Z);
         6'd18: u = alu(OP_MUL, fl, RF_E1X, RF_E1X, 1'b0);
         6'd19: u = alu(OP_MUL, RF_T, RF_E1Y, RF_E1Y, 1'b0);
         6'd20: u = alu(OP_ADD, fl, fl, RF_T, 1'b0);
         6'd21: u = alu(OP_MUL, RF_T, RF_E1Z, RF_E1Z, 1'b0);
         6'd22: u = alu(OP_ADD, fl, fl, RF_T, 1'b1);
         6'd23: u = alu(OP_MUL, fb, RF_E1X, RF_E2X, 1'b0);
         6'd24: u = alu(OP_MUL, RF_T, RF_E1Y, RF_E2Y, 1'b0);
         6'd25: u = alu(OP_ADD, fb, fb, RF_T, 1'b0);
         6'd26: u = alu(OP_MUL, RF_T, RF_E1Z, RF_E2Z, 1'b0);
         6'd27: u = alu(OP_ADD, fb, fb, RF_T, 1'b0);
         6'd28: u = alu(OP_MUL, RF_T, RF_N1, RF_E1Z, 1'b0);
         6'd29: u = alu(OP_MUL, RF_U, RF_N2, RF_E1Y, 1'b0);
         6'd30: u = alu(OP_SUB, RF_T, RF_T, RF_U, 1'b0);
         6'd31: u = alu(OP_MUL, fc, RF_E2X, RF_T, 1'b0);
         6'd32: u = alu(OP_MUL, RF_T, RF_N2, RF_E1X, 1'b0);
         6'd33: u = alu(OP_MUL, RF_U, RF_N0, RF_E1Z, 1'b0);
         6'd34: u = alu(OP_SUB, RF_T, RF_T, RF_U, 1'b0);
         6'd35: u = alu(OP_MUL, RF_U, RF_E2Y, RF_T, 1'b0);
         6'd36: u = alu(OP_ADD, fc, fc, RF_U, 1'b0);
         6'd37: u = alu(OP_MUL, RF_T, RF_N0, RF_E1Y, 1'b0);
         6'd38: u = alu(OP_MUL, RF_U, RF_N1, RF_E1X, 1'b0);
         6'd39: u = alu(OP_SUB, RF_T, RF_T, RF_U, 1'b0);
         6'd40: u = alu(OP_MUL, RF_U, RF_E2Z, RF_T, 1'b0);
         6'd41: u = alu(OP_ADD, fc, fc, RF_U, 1'b1);
         default: u = alu(OP_ADD, RF_T, RF_T, RF_T, 1'b0);
      endcase
      return u;
   endfunction

   // numerator, denominator and the rounding divide
   function automatic uop_type final_uop(logic [4:0] idx);
      uop_type u;
      case (idx)
         5'd0:  u = alu(OP_MUL, RF_LM, RF_L, RF_M, 1'b0);
         5'd1:  u = alu(OP_MUL, RF_C2, RF_C, RF_C, 1'b0);
         5'd2:  u = alu(OP_MUL, RF_R2, RF_R, RF_R, 1'b0);
         5'd3:  u = alu(OP_MUL, RF_T, RF_Q, RF_L, 1'b0);
         5'd4:  u = alu(OP_MUL, RF_U, RF_M, RF_B, 1'b0);
         5'd5:  u = alu(OP_SUB, RF_T, RF_T, RF_U, 1'b0);
         5'd6:  u = alu(OP_MUL, RF_T, RF_T, RF_T, 1'b0);
         5'd7:  u = alu(OP_MUL, RF_NUM, RF_R2, RF_LM, 1'b0);
         5'd8:  u = alu(OP_MUL, RF_U, RF_LM, RF_C2, 1'b0);
         5'd9:  u = alu(OP_ADD, RF_NUM, RF_NUM, RF_U, 1'b0);
         5'd10: u = alu(OP_MUL, RF_U, RF_M, RF_M, 1'b0);
         5'd11: u = alu(OP_MUL, RF_U, RF_U, RF_C2, 1'b0);
         5'd12: u = alu(OP_ADD, RF_NUM, RF_NUM, RF_U, 1'b0);
         5'd13: u = alu(OP_ADD, RF_NUM, RF_NUM, RF_T, 1'b0);
         5'd14: u = alu(OP_MUL, RF_U, RF_L, RF_L, 1'b0);
         5'd15: u = alu(OP_MUL, RF_U, RF_R2, RF_U, 1'b0);
         5'd16: u = alu(OP_ADD, RF_NUM, RF_NUM, RF_U, 1'b0);
         5'd17: u = alu(OP_MUL, RF_DEN, RF_LM, RF_C, 1'b0);
         5'd18: u = alu(OP_MUL, RF_DEN, RF_DEN, RF_R, 1'b0);
         5'd19: u = alu(OP_ABS, RF_DEN, RF_DEN, RF_DEN, 1'b0);
         default: u = alu(OP_DIV, RF_T, RF_NUM, RF_DEN, 1'b0);
      endcase
      return u;
   endfunction

   function automatic uop_type uop_rom(logic [PC_BITS-1:0] pc);
      uop_type u;
      if (pc < PC_BITS'(FRAME_LEN)) begin
         u = frame_uop(6'(pc), ROW_BITS'(0), RF_L, RF_B, RF_C);
      end else if (pc < PC_BITS'(2 * FRAME_LEN)) begin
         u = frame_uop(6'(pc - PC_BITS'(FRAME_LEN)), ROW_BITS'(4), RF_M, RF_Q, RF_R);
      end else begin
         u = final_uop(5'(pc - PC_BITS'(2 * FRAME_LEN)));
      end
      return u;
   endfunction

endpackage

// ===== src/tmd_if.sv =====
// input vector channel
interface tmd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [2:0]                            kind;
   logic signed [tmd_pkg::COORD_BITS-1:0] coord_x;
   logic signed [tmd_pkg::COORD_BITS-1:0] coord_y;
   logic signed [tmd_pkg::COORD_BITS-1:0] coord_z;

   modport source (output valid, kind, coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, kind, coord_x, coord_y, coord_z, output ready);
endinterface

// result channel
interface tmd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tmd_pkg::DIST_BITS-1:0]  distortion;
   logic                           degenerate;
   logic                           saturated;

   modport source (output valid, distortion, degenerate, saturated, input ready);
   modport sink   (input valid, distortion, degenerate, saturated, output ready);
endinterface

// ===== src/tmd_alu.sv =====
module tmd_alu (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  tmd_pkg::alu_op_type      op,
   input  tmd_pkg::wide_type        opd_a,
   input  tmd_pkg::wide_type        opd_b,
   output tmd_pkg::wide_type        res,
   output logic [tmd_pkg::DIST_BITS-1:0] quo,
   output tmd_pkg::alu_status_type  status
);

   localparam int W = tmd_pkg::WIDE_BITS;
   localparam int D = tmd_pkg::DIST_BITS;

   tmd_pkg::alu_state_type state_ff, state_in;
   tmd_pkg::wide_type      acc_ff, acc_in;
   tmd_pkg::wide_type      opa_ff, opa_in;
   tmd_pkg::wide_type      opb_ff, opb_in;
   logic [D-1:0]           quo_ff, quo_in;
   logic                   sat_ff, sat_in;
   logic                   neg_ff, neg_in;
   logic [tmd_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;

   tmd_pkg::wide_type abs_a;
   tmd_pkg::wide_type abs_b;
   tmd_pkg::wide_type rem_sh;
   tmd_pkg::wide_type clamp;
   logic              rem_ge;

   // magnitudes and divider step terms
   assign abs_a  = opd_a[W-1] ? (~opd_a) + tmd_pkg::wide_type'(1) : opd_a;
   assign abs_b  = opd_b[W-1] ? (~opd_b) + tmd_pkg::wide_type'(1) : opd_b;
   assign rem_sh = {acc_ff[W-2:0], opa_ff[W-1]};
   assign rem_ge = (rem_sh >= opb_ff);
   assign clamp  = opa_ff[W-1] ? '0 : opa_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmd_pkg::ALU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // sequencing of one operation
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      quo_in   = quo_ff;
      sat_in   = sat_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         tmd_pkg::ALU_IDLE: begin
            if (start) begin
               unique case (op)
                  tmd_pkg::OP_LD: begin
                     acc_in   = opd_a;
                     state_in = tmd_pkg::ALU_DONE;
                  end
                  tmd_pkg::OP_ADD: begin
                     acc_in   = opd_a + opd_b;
                     state_in = tmd_pkg::ALU_DONE;
                  end
                  tmd_pkg::OP_SUB: begin
                     acc_in   = opd_a - opd_b;
                     state_in = tmd_pkg::ALU_DONE;
                  end
                  tmd_pkg::OP_ABS: begin
                     acc_in   = abs_a;
                     state_in = tmd_pkg::ALU_DONE;
                  end
                  tmd_pkg::OP_MUL: begin
                     opa_in   = abs_a;
                     opb_in   = abs_b;
                     acc_in   = '0;
                     neg_in   = opd_a[W-1] ^ opd_b[W-1];
                     state_in = tmd_pkg::ALU_MUL;
                  end
                  tmd_pkg::OP_DIV: begin
                     // numerator minus four times the denominator
                     opa_in   = opd_a - {opd_b[W-3:0], 2'b00};
                     opb_in   = opd_b;
                     state_in = tmd_pkg::ALU_DPREP;
                  end
                  default: begin
                     state_in = tmd_pkg::ALU_DONE;
                  end
               endcase
            end
         end
         tmd_pkg::ALU_MUL: begin
            // shift-add, stops once the multiplier runs out of ones
            if (opb_ff == '0) begin
               state_in = tmd_pkg::ALU_SIGN;
            end else begin
               if (opb_ff[0]) begin
                  acc_in = acc_ff + opa_ff;
               end
               opa_in = {opa_ff[W-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[W-1:1]};
            end
         end
         tmd_pkg::ALU_SIGN: begin
            acc_in   = neg_ff ? (~acc_ff) + tmd_pkg::wide_type'(1) : acc_ff;
            state_in = tmd_pkg::ALU_DONE;
         end
         tmd_pkg::ALU_DPREP: begin
            // scaled dividend plus half divisor for round to nearest
            opa_in   = (clamp << (tmd_pkg::FRAC_BITS + 1)) + opb_ff;
            opb_in   = {opb_ff[W-2:0], 1'b0};
            acc_in   = '0;
            quo_in   = '0;
            sat_in   = 1'b0;
            cnt_in   = '0;
            state_in = tmd_pkg::ALU_DIV;
         end
         tmd_pkg::ALU_DIV: begin
            // restoring division, one quotient bit a cycle
            opa_in = {opa_ff[W-2:0], 1'b0};
            acc_in = rem_ge ? rem_sh - opb_ff : rem_sh;
            quo_in = {quo_ff[D-2:0], rem_ge};
            sat_in = sat_ff | quo_ff[D-1];
            cnt_in = cnt_ff + tmd_pkg::CNT_BITS'(1);
            if (cnt_ff == tmd_pkg::CNT_LAST) begin
               state_in = tmd_pkg::ALU_DONE;
            end
         end
         tmd_pkg::ALU_DONE: begin
            state_in = tmd_pkg::ALU_IDLE;
         end
         default: begin
            state_in = tmd_pkg::ALU_IDLE;
         end
      endcase
   end

   assign res         = acc_ff;
   assign quo         = quo_ff;
   assign status.done = (state_ff == tmd_pkg::ALU_DONE);
   assign status.sat  = sat_ff;

endmodule

// ===== src/tmd_seq.sv =====
module tmd_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              vec_we,
   input  logic [tmd_pkg::ROW_BITS-1:0]      vec_row,
   input  logic [tmd_pkg::VEC_BITS-1:0]      vec_data,
   input  logic                              take,
   output logic                              res_valid,
   output tmd_pkg::result_type               res
);

   localparam int W = tmd_pkg::WIDE_BITS;
   localparam int C = tmd_pkg::COORD_BITS;

   tmd_pkg::seq_state_type       state_ff, state_in;
   logic [tmd_pkg::PC_BITS-1:0]  pc_ff, pc_in;
   logic                         degen_ff, degen_in;
   tmd_pkg::result_type          res_ff, res_in;

   logic [tmd_pkg::VEC_BITS-1:0] vec_mem [tmd_pkg::SLOTS];
   tmd_pkg::wide_type            rf_mem [tmd_pkg::RF_DEPTH];
   logic [tmd_pkg::VEC_BITS-1:0] vec_rd_ff;
   tmd_pkg::wide_type            rd_a_ff;
   tmd_pkg::wide_type            rd_b_ff;

   tmd_pkg::uop_type             uop;
   logic [C-1:0]                 comp_word;
   tmd_pkg::wide_type            alu_a;
   tmd_pkg::wide_type            alu_res;
   logic [tmd_pkg::DIST_BITS-1:0] alu_quo;
   tmd_pkg::alu_status_type      alu_st;
   logic                         alu_start;
   logic                         rf_we;

   assign uop = tmd_pkg::uop_rom(pc_ff);

   // vector store, one row per slot
   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[vec_row] <= vec_data;
      end
      vec_rd_ff <= vec_mem[uop.slot];
   end

   // working register file, two read ports
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[uop.dst] <= alu_res;
      end
      rd_a_ff <= rf_mem[uop.a];
      rd_b_ff <= rf_mem[uop.b];
   end

   // component pick for loads
   always_comb begin
      case (uop.comp)
         tmd_pkg::COMP_Y: comp_word = vec_rd_ff[2*C-1:C];
         tmd_pkg::COMP_Z: comp_word = vec_rd_ff[3*C-1:2*C];
         default:         comp_word = vec_rd_ff[C-1:0];
      endcase
   end

   assign alu_a = (uop.op == tmd_pkg::OP_LD) ? {{(W-C){comp_word[C-1]}}, comp_word}
                                             : rd_a_ff;

   tmd_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .op     (uop.op),
      .opd_a  (alu_a),
      .opd_b  (rd_b_ff),
      .res    (alu_res),
      .quo    (alu_quo),
      .status (alu_st)
   );

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmd_pkg::SEQ_IDLE;
         pc_ff    <= '0;
         degen_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         degen_ff <= degen_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // micro-op stepping
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      degen_in  = degen_ff;
      res_in    = res_ff;
      alu_start = 1'b0;
      rf_we     = 1'b0;
      unique case (state_ff)
         tmd_pkg::SEQ_IDLE: begin
            if (start) begin
               pc_in    = '0;
               degen_in = 1'b0;
               state_in = tmd_pkg::SEQ_READ;
            end
         end
         tmd_pkg::SEQ_READ: begin
            state_in = tmd_pkg::SEQ_EXEC;
         end
         tmd_pkg::SEQ_EXEC: begin
            alu_start = 1'b1;
            state_in  = tmd_pkg::SEQ_WAIT;
         end
         tmd_pkg::SEQ_WAIT: begin
            if (alu_st.done) begin
               rf_we = (uop.op != tmd_pkg::OP_DIV);
               if (uop.zchk && (alu_res == '0)) begin
                  degen_in = 1'b1;
               end
               if (pc_ff == tmd_pkg::UOP_LAST) begin
                  // degenerate frames override the quotient
                  res_in.degenerate = degen_ff;
                  res_in.saturated  = !degen_ff && alu_st.sat;
                  res_in.distortion = (degen_ff || alu_st.sat) ? tmd_pkg::DIST_MAX
                                                               : alu_quo;
                  state_in = tmd_pkg::SEQ_HOLD;
               end else begin
                  pc_in    = pc_ff + tmd_pkg::PC_BITS'(1);
                  state_in = tmd_pkg::SEQ_READ;
               end
            end
         end
         tmd_pkg::SEQ_HOLD: begin
            if (take) begin
               state_in = tmd_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = tmd_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign res_valid = (state_ff == tmd_pkg::SEQ_HOLD);
   assign res       = res_ff;

endmodule

// ===== src/triangle_map_distortion.sv =====
// Triangle map distortion: area plus angle distortion of the map between two triangles.
// req_if carries one 3-vector per transfer, tagged by kind: 0..2 original vertices,
// 3 original normal, 4..6 deformed vertices, 7 deformed normal. A slot sent twice
// keeps the later vector. Once all eight slots have arrived, the block computes
// one result on rsp_if: distortion in unsigned Q32.16 (rounded, saturating at
// the maximum), degenerate for a zero edge or zero frame determinant, and
// saturated when the value was clipped.
// Vector transfers that do not complete a set give no result.
// The completing transfer starts a microcoded run of 105 steps on one shared
// shift-add multiplier / restoring divider; each multiply ends once its
// multiplier operand runs out of ones. req_if.ready is low from the completing
// transfer until its result moves into the output register.
// The output register holds a result while rsp_if.ready is low; storing
// transfers go on meanwhile, and a finished run waits for the register.
// Reset clears the slot mask and all handshake state; stored vectors are kept
// undefined until written.
`include "triangle_map_distortion_assert.svh"

module triangle_map_distortion (
   input  logic     clock,
   input  logic     reset,
   tmd_req_if.sink  req_if,
   tmd_rsp_if.source rsp_if
);

   logic [tmd_pkg::SLOTS-1:0] slots_ff, slots_in;
   logic                      busy_ff, busy_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   tmd_pkg::result_type       rsp_res_ff, rsp_res_in;

   logic [tmd_pkg::SLOTS-1:0] slots_next;
   logic                      req_xfer;
   logic                      complete;
   logic                      seq_valid;
   tmd_pkg::result_type       seq_res;
   logic                      take;

   // input side
   assign req_if.ready = !busy_ff && !reset;
   assign req_xfer     = req_if.valid && req_if.ready;
   assign slots_next   = slots_ff | (tmd_pkg::SLOTS'(1) << req_if.kind);
   assign complete     = (slots_next == '1);
   assign take         = seq_valid && (!rsp_valid_ff || rsp_if.ready);

   tmd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_xfer && complete),
      .vec_we    (req_xfer),
      .vec_row   (req_if.kind),
      .vec_data  ({req_if.coord_z, req_if.coord_y, req_if.coord_x}),
      .take      (take),
      .res_valid (seq_valid),
      .res       (seq_res)
   );

   // slot mask, busy flag and output register control
   always_comb begin
      slots_in     = slots_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (req_xfer) begin
         if (complete) begin
            slots_in = '0;
            busy_in  = 1'b1;
         end else begin
            slots_in = slots_next;
         end
      end
      if (take) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_res_in   = seq_res;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slots_ff     <= slots_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.distortion = rsp_res_ff.distortion;
   assign rsp_if.degenerate = rsp_res_ff.degenerate;
   assign rsp_if.saturated  = rsp_res_ff.saturated;

   // checks
   `TMD_ASSERT_IMPLY(a_result_while_busy, clock, reset, seq_valid, busy_ff)
   `TMD_ASSERT_NEXT(a_complete_sets_busy, clock, reset, req_xfer && complete, busy_ff && (slots_ff == '0))
   `TMD_ASSERT_IMPLY(a_degenerate_form, clock, reset, rsp_valid_ff && rsp_res_ff.degenerate, !rsp_res_ff.saturated && (rsp_res_ff.distortion == tmd_pkg::DIST_MAX))

endmodule

// ===== tb/sv/triangle_map_distortion_test.sv =====
module triangle_map_distortion_test;

   typedef logic signed [383:0] big_type;

   // directed stimulus row, with an optional hand-typed result
   typedef struct {
      logic [2:0]           kind;
      logic [31:0]          x;
      logic [31:0]          y;
      logic [31:0]          z;
      bit                   typed;
      tmd_pkg::result_type  res;
   } vec_row_type;

   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN_WAIT  = 4000;
   localparam int ITEM_TARGET = 400;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] CMAX = 32'h7fff_ffff;
   localparam logic [31:0] CMIN = 32'h8000_0000;

   logic clock;
   logic reset;

   tmd_req_if req_ch ();
   tmd_rsp_if rsp_ch ();

   triangle_map_distortion dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // predictor state
   logic [31:0]         vec_store [24];
   logic [7:0]          slot_mask;
   tmd_pkg::result_type dist_q [$];

   int errors;
   int items_sent;
   int results_seen;
   int degen_seen;
   int sat_seen;
   int idle_cycles;
   bit quiet;

   always #5 clock = ~clock;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   // edge length squared, e1.e2 and n.(e1 x e2) of one triangle
   function automatic void frame_terms(input int base, output big_type len2,
                                       output big_type dot, output big_type det);
      big_type e1 [3];
      big_type e2 [3];
      big_type n [3];
      big_type cr [3];
      for (int k = 0; k < 3; k++) begin
         e1[k] = big_type'($signed(vec_store[(base + 1) * 3 + k]))
               - big_type'($signed(vec_store[base * 3 + k]));
         e2[k] = big_type'($signed(vec_store[(base + 2) * 3 + k]))
               - big_type'($signed(vec_store[base * 3 + k]));
         n[k]  = big_type'($signed(vec_store[(base + 3) * 3 + k]));
      end
      len2 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
      dot  = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
      cr[0] = n[1] * e1[2] - n[2] * e1[1];
      cr[1] = n[2] * e1[0] - n[0] * e1[2];
      cr[2] = n[0] * e1[1] - n[1] * e1[0];
      det  = e2[0] * cr[0] + e2[1] * cr[1] + e2[2] * cr[2];
   endfunction

   // distortion of the stored triangle pair
   function automatic tmd_pkg::result_type distortion_of_pair();
      big_type l, b, c, m, q, r, lm, t, num, den, x, quo;
      tmd_pkg::result_type res;
      frame_terms(0, l, b, c);
      frame_terms(4, m, q, r);
      res.distortion = tmd_pkg::DIST_MAX;
      res.degenerate = 1'b0;
      res.saturated  = 1'b0;
      if (l == 0 || m == 0 || c == 0 || r == 0) begin
         res.degenerate = 1'b1;
         return res;
      end
      lm  = l * m;
      t   = q * l - m * b;
      num = r * r * lm + lm * c * c + m * m * c * c + t * t + r * r * l * l;
      if (c < 0) c = -c;
      if (r < 0) r = -r;
      den = lm * c * r;
      x   = (num < 4 * den) ? big_type'(0) : num - 4 * den;
      x   = (x <<< (tmd_pkg::FRAC_BITS + 1)) + den;
      quo = x / (2 * den);
      if (quo >= (big_type'(1) <<< tmd_pkg::DIST_BITS)) res.saturated = 1'b1;
      else res.distortion = quo[tmd_pkg::DIST_BITS-1:0];
      return res;
   endfunction

   // store one accepted vector; true when it completes a set
   function automatic bit store_vector(input logic [2:0] kind, input logic [31:0] x,
                                       input logic [31:0] y, input logic [31:0] z);
      vec_store[kind * 3]     = x;
      vec_store[kind * 3 + 1] = y;
      vec_store[kind * 3 + 2] = z;
      slot_mask[kind] = 1'b1;
      if (slot_mask != 8'hff) return 1'b0;
      slot_mask = '0;
      return 1'b1;
   endfunction

   function automatic int draw_gap();
      return quiet ? 0 : int'($urandom_range(0, 17));
   endfunction

   // one input transfer; typed rows override the predicted result
   task automatic send_vector(input logic [2:0] kind, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z,
                              input bit typed, input tmd_pkg::result_type typed_res);
      int gap;
      tmd_pkg::result_type pred;
      gap = draw_gap();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.coord_x <= x;
      req_ch.coord_y <= y;
      req_ch.coord_z <= z;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (store_vector(kind, x, y, z)) begin
         pred = distortion_of_pair();
         dist_q.push_back(typed ? typed_res : pred);
      end
   endtask

   function automatic logic [31:0] rand_coord(input int scale);
      case (scale)
         0: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
         1: return $urandom();
         default: return ($urandom_range(0, 1) != 0) ? $urandom()
                          : 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      endcase
   endfunction

   // one set of eight slots in random order, at times cut short, with some faults mixed in
   task automatic send_random_set();
      logic [31:0] vec [8][3];
      logic [2:0]  order [8];
      logic [2:0]  tmp;
      int scale, j, k;
      tmd_pkg::result_type none;
      none = '0;
      scale = $urandom_range(0, 2);
      for (int s = 0; s < 8; s++) begin
         order[s] = 3'(s);
         for (k = 0; k < 3; k++) vec[s][k] = rand_coord(scale);
      end
      // degenerate frames now and then
      case ($urandom_range(0, 19))
         0: for (k = 0; k < 3; k++) vec[1][k] = vec[0][k];
         1: for (k = 0; k < 3; k++) vec[5][k] = vec[4][k];
         2: for (k = 0; k < 3; k++) vec[3][k] = '0;
         3: for (k = 0; k < 3; k++) vec[7][k] = '0;
         4: for (k = 0; k < 3; k++) vec[6][k] = vec[4][k];
         default: ;
      endcase
      for (int s = 7; s > 0; s--) begin
         j = $urandom_range(0, s);
         tmp = order[s];
         order[s] = order[j];
         order[j] = tmp;
      end
      // broken set: a few slots only, left for the next set to complete
      if ($urandom_range(0, 9) == 0) begin
         for (int s = 0; s < int'($urandom_range(1, 6)); s++)
            send_vector(order[s], vec[order[s]][0], vec[order[s]][1], vec[order[s]][2],
                        1'b0, none);
         return;
      end
      for (int s = 0; s < 8; s++) begin
         send_vector(order[s], vec[order[s]][0], vec[order[s]][1], vec[order[s]][2],
                     1'b0, none);
         // overwrite of a slot already sent
         if (s < 7 && $urandom_range(0, 6) == 0) begin
            j = $urandom_range(0, s);
            send_vector(order[j], rand_coord(scale), rand_coord(scale), rand_coord(scale),
                        1'b0, none);
         end
      end
   endtask

   function automatic vec_row_type mk_row(input logic [2:0] kind, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z,
                                          input bit typed, input logic [47:0] dist_val,
                                          input logic degen, input logic sat);
      vec_row_type r;
      r.kind = kind;
      r.x = x;
      r.y = y;
      r.z = z;
      r.typed = typed;
      r.res.distortion = dist_val;
      r.res.degenerate = degen;
      r.res.saturated  = sat;
      return r;
   endfunction

   // result side: random stalls, field compare against the oldest expectation
   initial begin
      int gap;
      tmd_pkg::result_type want;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         repeat (gap) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         results_seen++;
         if (rsp_ch.degenerate) degen_seen++;
         if (rsp_ch.saturated) sat_seen++;
         if (dist_q.size() == 0) begin
            report("unexpected result", 64'(rsp_ch.distortion), '0);
         end else begin
            want = dist_q.pop_front();
            if (rsp_ch.distortion !== want.distortion)
               report("distortion", 64'(rsp_ch.distortion), 64'(want.distortion));
            if (rsp_ch.degenerate !== want.degenerate)
               report("degenerate", 64'(rsp_ch.degenerate), 64'(want.degenerate));
            if (rsp_ch.saturated !== want.saturated)
               report("saturated", 64'(rsp_ch.saturated), 64'(want.saturated));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", dist_q.size());
            $display("triangle_map_distortion_test NOT OK");
            $finish;
         end
      end
   end

   initial begin
      vec_row_type rows [$];
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = '0;
      req_ch.coord_x = '0;
      req_ch.coord_y = '0;
      req_ch.coord_z = '0;
      rsp_ch.ready = 1'b0;
      slot_mask = '0;
      errors = 0;
      items_sent = 0;
      results_seen = 0;
      degen_seen = 0;
      sat_seen = 0;
      idle_cycles = 0;
      quiet = 1'b0;
      foreach (vec_store[i]) vec_store[i] = '0;

      // identical unit triangles: no distortion
      rows.push_back(mk_row(3'd0, 0, 0, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd1, ONE, 0, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd2, 0, ONE, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd3, 0, 0, ONE, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd4, 0, 0, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd5, ONE, 0, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd6, 0, ONE, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd7, 0, 0, ONE, 1'b1, '0, 1'b0, 1'b0));
      // zero deformed normal, slot written twice with extremes first
      rows.push_back(mk_row(3'd4, CMIN, CMIN, CMIN, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd7, 0, 0, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd0, CMIN, CMAX, CMIN, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd1, CMAX, CMIN, CMAX, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd2, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
                            1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd3, CMAX, CMAX, CMIN, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd4, 0, 0, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd5, ONE, 0, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd6, 0, ONE, 0, 1'b1, tmd_pkg::DIST_MAX, 1'b1, 1'b0));
      // tiny original, huge deformed: clipped
      rows.push_back(mk_row(3'd0, 0, 0, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd1, 1, 0, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd2, 0, 1, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd3, 0, 0, 1, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd4, 0, 0, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd5, CMAX, 0, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd6, 0, CMAX, 0, 1'b0, '0, 1'b0, 1'b0));
      rows.push_back(mk_row(3'd7, 0, 0, CMAX, 1'b1, tmd_pkg::DIST_MAX, 1'b0, 1'b1));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_vector(rows[i].kind, rows[i].x, rows[i].y, rows[i].z, rows[i].typed,
                     rows[i].res);

      // random sets, with a full drain now and then
      for (int n = 0; items_sent < ITEM_TARGET; n++) begin
         if ($urandom_range(0, 4) == 0) quiet = ~quiet;
         if (n % 12 == 5) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            while (dist_q.size() != 0) @(posedge clock);
         end
         send_random_set();
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (dist_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d vectors, checked %0d results", items_sent, results_seen);
      $display("degenerate results %0d, clipped results %0d", degen_seen, sat_seen);
      if (errors == 0) begin
         $display("triangle_map_distortion_test OK");
      end else begin
         $display("triangle_map_distortion_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/tmd_pkg.sv
src/tmd_if.sv
src/tmd_alu.sv
src/tmd_seq.sv
src/triangle_map_distortion.sv
tb/sv/triangle_map_distortion_test.sv
